/* hw/rtl/sbct_pkg.sv */
// Shared types and codes for the sorted barcode count table.
`default_nettype none

package sbct_pkg;

  // Fixed field widths
  localparam int CodeW = 48;
  localparam int RposW = 8;
  localparam int OccW  = 32;
  localparam int UsedW = 9;

  // Parameter defaults
  localparam int DefTableDepth = 256;
  localparam int DefKeyBases   = 16;
  localparam int DefCountBits  = 32;

  // Request opcodes
  localparam logic OpRecord = 1'b0;
  localparam logic OpRead   = 1'b1;

  // Token modes as the request walks the chain
  localparam logic [2:0] ModeSearch = 3'd0;  // looking for first entry not below key
  localparam logic [2:0] ModeShift  = 3'd1;  // inserted, carrying displaced entry up
  localparam logic [2:0] ModeHit    = 3'd2;  // key found, count bumped
  localparam logic [2:0] ModeDrop   = 3'd3;  // miss on a full table
  localparam logic [2:0] ModeIns    = 3'd4;  // insertion finished
  localparam logic [2:0] ModeRead   = 3'd5;  // looking for the read position
  localparam logic [2:0] ModeRdone  = 3'd6;  // entry read out
  localparam logic [2:0] ModeBad    = 3'd7;  // read position not in use

  typedef struct packed {
    logic             opcode;
    logic [CodeW-1:0] first_code;
    logic [CodeW-1:0] second_code;
    logic [RposW-1:0] read_position;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             inserted;
    logic             full_drop;
    logic [RposW-1:0] position;
    logic [OccW-1:0]  occurrences;
    logic [CodeW-1:0] entry_first;
    logic [CodeW-1:0] entry_second;
    logic [UsedW-1:0] entries_used;
    logic             bad_position;
  } rsp_t;

  // Control part of the token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [2:0]       mode;
    logic [CodeW-1:0] key_first;
    logic [CodeW-1:0] key_second;
  } token_t;

endpackage

`default_nettype wire

/* hw/rtl/sbct_cell.sv */
// One table slot of the sorted barcode count table, with its token stage.
`default_nettype none

module sbct_cell
  import sbct_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int COUNT_BITS  = DefCountBits,
  parameter int IDX         = 0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                dual_i,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    used_i,
  input  wire token_t                              tok_i,
  input  wire logic [COUNT_BITS-1:0]               cnt_i,
  input  wire logic [((($clog2(TABLE_DEPTH)) > 8) ?
                      $clog2(TABLE_DEPTH) : 8)-1:0] pos_i,
  output      token_t                              tok_o,
  output      logic [COUNT_BITS-1:0]               cnt_o,
  output      logic [((($clog2(TABLE_DEPTH)) > 8) ?
                      $clog2(TABLE_DEPTH) : 8)-1:0] pos_o
);

  localparam int UW   = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int PosW = (IdxW > 8) ? IdxW : 8;
  localparam logic [UW-1:0]         IdxU   = UW'(IDX);
  localparam logic [UW-1:0]         DepthU = UW'(TABLE_DEPTH);
  localparam logic [PosW-1:0]       IdxP   = PosW'(IDX);
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  // Stored entry (no reset: contents are valid only below used_i)
  logic [CodeW-1:0]      ent_k1_q, ent_k1_d;
  logic [CodeW-1:0]      ent_k2_q, ent_k2_d;
  logic [COUNT_BITS-1:0] ent_cnt_q, ent_cnt_d;
  logic                  ent_we;

  token_t                tok_q, tok_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [PosW-1:0]       pos_q, pos_d;

  logic                  live, at_end, full, key_lt, key_eq;
  logic [COUNT_BITS-1:0] cnt_sat;

  assign live    = IdxU < used_i;
  assign at_end  = IdxU == used_i;
  assign full    = used_i == DepthU;
  assign key_eq  = (ent_k1_q == tok_i.key_first) &&
                   (!dual_i || (ent_k2_q == tok_i.key_second));
  assign key_lt  = (ent_k1_q < tok_i.key_first) ||
                   ((ent_k1_q == tok_i.key_first) && dual_i &&
                    (ent_k2_q < tok_i.key_second));
  assign cnt_sat = (&ent_cnt_q) ? ent_cnt_q : ent_cnt_q + CntOne;

  always_comb begin
    tok_d     = tok_i;
    cnt_d     = cnt_i;
    pos_d     = pos_i;
    ent_we    = 1'b0;
    ent_k1_d  = ent_k1_q;
    ent_k2_d  = ent_k2_q;
    ent_cnt_d = ent_cnt_q;
    if (tok_i.valid) begin
      case (tok_i.mode)
        ModeSearch: begin
          if (live && !key_lt) begin
            if (key_eq) begin
              ent_we     = 1'b1;
              ent_cnt_d  = cnt_sat;
              tok_d.mode = ModeHit;
              cnt_d      = cnt_sat;
              pos_d      = IdxP;
            end else if (full) begin
              tok_d.mode = ModeDrop;
              cnt_d      = '0;
              pos_d      = '0;
            end else begin
              // take the new key here, push the old entry up the chain
              ent_we           = 1'b1;
              ent_k1_d         = tok_i.key_first;
              ent_k2_d         = tok_i.key_second;
              ent_cnt_d        = CntOne;
              tok_d.mode       = ModeShift;
              tok_d.key_first  = ent_k1_q;
              tok_d.key_second = ent_k2_q;
              cnt_d            = ent_cnt_q;
              pos_d            = IdxP;
            end
          end else if (at_end) begin
            ent_we     = 1'b1;
            ent_k1_d   = tok_i.key_first;
            ent_k2_d   = tok_i.key_second;
            ent_cnt_d  = CntOne;
            tok_d.mode = ModeIns;
            cnt_d      = CntOne;
            pos_d      = IdxP;
          end
        end
        ModeShift: begin
          if (live) begin
            ent_we           = 1'b1;
            ent_k1_d         = tok_i.key_first;
            ent_k2_d         = tok_i.key_second;
            ent_cnt_d        = cnt_i;
            tok_d.key_first  = ent_k1_q;
            tok_d.key_second = ent_k2_q;
            cnt_d            = ent_cnt_q;
          end else if (at_end) begin
            ent_we     = 1'b1;
            ent_k1_d   = tok_i.key_first;
            ent_k2_d   = tok_i.key_second;
            ent_cnt_d  = cnt_i;
            tok_d.mode = ModeIns;
          end
        end
        ModeRead: begin
          if (pos_i == IdxP) begin
            if (live) begin
              tok_d.mode       = ModeRdone;
              tok_d.key_first  = ent_k1_q;
              tok_d.key_second = ent_k2_q;
              cnt_d            = ent_cnt_q;
            end else begin
              tok_d.mode = ModeBad;
            end
          end
        end
        default: ;  // finished tokens pass through
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    pos_q <= pos_d;
    if (ent_we) begin
      ent_k1_q  <= ent_k1_d;
      ent_k2_q  <= ent_k2_d;
      ent_cnt_q <= ent_cnt_d;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;
  assign pos_o = pos_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_barcode_count_table_core.sv */
// Top level of the sorted barcode count table: request entry, cell chain, result queue.
`default_nettype none

// Sorted barcode count table. Holds up to TABLE_DEPTH distinct barcode keys in
// ascending order, each with a saturating COUNT_BITS-bit occurrence count, in a
// row of TABLE_DEPTH cells; cell i holds table position i. A record request
// (opcode 0) looks up its key (first_code, or first_code then second_code when
// dual_index is set); a hit bumps the count, a miss inserts the key at its
// sorted place with count 1 while the cells above hand their entries up by one,
// and a miss on a full table is dropped and flagged. A read request (opcode 1)
// returns the entry at read_position. Each request travels as a token through
// the whole chain, one cell per clock, and its result is registered in the
// output register once the token leaves the last cell. A new request is
// accepted only after the token of the previous one has left the last cell,
// so the chain holds one request at a time. A two-deep result queue lets a
// new request enter while an earlier result still waits on out_stall_i. The
// table starts empty; no clearing pass is needed. dual_index is written with
// cfg_we_i and should only change while no request is in flight.
module sorted_barcode_count_table_core
  import sbct_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int KEY_BASES   = DefKeyBases,
  parameter int COUNT_BITS  = DefCountBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_data_i,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  input  wire req_t in_data_i,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      rsp_t out_data_o
);

  localparam int UW    = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW  = $clog2(TABLE_DEPTH);
  localparam int PosW  = (IdxW > 8) ? IdxW : 8;
  localparam int KeyW  = 3 * KEY_BASES;
  localparam logic [CodeW-1:0] KeyMask =
    (KeyW >= CodeW) ? {CodeW{1'b1}} : CodeW'((64'(1) << KeyW) - 64'(1));
  localparam logic [UW-1:0] UsedOne = UW'(1);

  logic          dual_q;
  logic [UW-1:0] used_q, used_d;
  logic          busy_q;
  logic          accept;

  token_t                tok_w [TABLE_DEPTH+1];
  logic [COUNT_BITS-1:0] cnt_w [TABLE_DEPTH+1];
  logic [PosW-1:0]       pos_w [TABLE_DEPTH+1];

  // Result queue: output register plus one skid slot
  rsp_t out_q, out_d, pend_q, pend_d, res;
  logic out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic res_valid, res_ins;

  assign in_stall_o = busy_q || pend_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Token injection into cell 0
  always_comb begin
    tok_w[0].valid      = accept;
    tok_w[0].mode       = (in_data_i.opcode == OpRead) ? ModeRead : ModeSearch;
    tok_w[0].key_first  = in_data_i.first_code & KeyMask;
    tok_w[0].key_second = dual_q ? (in_data_i.second_code & KeyMask) : '0;
    cnt_w[0]            = '0;
    pos_w[0]            = (in_data_i.opcode == OpRead) ? PosW'(in_data_i.read_position) : '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sbct_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COUNT_BITS (COUNT_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .dual_i(dual_q),
      .used_i(used_q),
      .tok_i (tok_w[g]),
      .cnt_i (cnt_w[g]),
      .pos_i (pos_w[g]),
      .tok_o (tok_w[g+1]),
      .cnt_o (cnt_w[g+1]),
      .pos_o (pos_w[g+1])
    );
  end

  // Result built from the token leaving the last cell
  assign res_valid = tok_w[TABLE_DEPTH].valid;
  assign res_ins   = (tok_w[TABLE_DEPTH].mode == ModeIns) ||
                     (tok_w[TABLE_DEPTH].mode == ModeShift);
  assign used_d    = (res_valid && res_ins) ? used_q + UsedOne : used_q;

  always_comb begin
    res              = '0;
    res.entries_used = UsedW'(used_d);
    case (tok_w[TABLE_DEPTH].mode) inside
      ModeHit: begin
        res.hit         = 1'b1;
        res.position    = RposW'(pos_w[TABLE_DEPTH]);
        res.occurrences = OccW'(cnt_w[TABLE_DEPTH]);
      end
      ModeIns, ModeShift: begin
        res.inserted    = 1'b1;
        res.position    = RposW'(pos_w[TABLE_DEPTH]);
        res.occurrences = OccW'(1);
      end
      ModeRdone: begin
        res.position     = RposW'(pos_w[TABLE_DEPTH]);
        res.occurrences  = OccW'(cnt_w[TABLE_DEPTH]);
        res.entry_first  = tok_w[TABLE_DEPTH].key_first;
        res.entry_second = tok_w[TABLE_DEPTH].key_second;
      end
      ModeRead, ModeBad: begin
        // position beyond the chain or not in use
        res.position     = RposW'(pos_w[TABLE_DEPTH]);
        res.bad_position = 1'b1;
      end
      default: begin
        // drop, or a search that ran past a full table
        res.full_drop = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (!out_valid_d && pend_valid_q) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
    if (res_valid) begin
      if (!out_valid_d) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        pend_d       = res;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_q       <= 1'b0;
      used_q       <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dual_q <= cfg_data_i;
      end
      used_q       <= used_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (res_valid) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
